// ----- hw/rtl/dtwbt_pkg.sv -----
// Shared constants, codes and control structs of the DTW distance core.
`default_nettype none

package dtwbt_pkg;

    localparam int DEF_MAX_LENGTH  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int COST_W  = 40;
    localparam int CELLS_W = 6;
    localparam int LEN_W   = 6;
    localparam int OP_W    = 2;
    localparam int INDEX_W = 5;
    localparam int VALUE_W = 16;

    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
    localparam logic [CELLS_W-1:0] CELLS_MAX = {CELLS_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(32);

    // stream packing
    localparam int IN_INDEX_LSB  = 0;
    localparam int IN_VALUE_LSB  = IN_INDEX_LSB + INDEX_W;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_COST_LSB  = 0;
    localparam int OUT_CELLS_LSB = OUT_COST_LSB + COST_W;
    localparam int OUT_DATA_W    = 48;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_A_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_B_LENGTH = 1'b1;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic issue;
        logic walk;
        logic cap_up;
        logic cap_left;
        logic cap_diag;
        logic done;
    } dtwbt_cmd_t;

    typedef struct packed {
        logic busy;
        logic go_up;
        logic go_left;
    } dtwbt_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dtwbt_ctrl.sv -----
// Sequencer of the DTW core: handshake, matrix fill order and backtrack walk.
`default_nettype none

module dtwbt_ctrl
    import dtwbt_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [OP_W-1:0]                op,
    input  wire logic [LEN_W-1:0]               curve_a_length,
    input  wire logic [LEN_W-1:0]               curve_b_length,
    input  wire logic                           out_free,
    input  wire dtwbt_status_t                  status,
    output dtwbt_cmd_t                          cmd,
    output logic [$clog2(MAX_LENGTH)-1:0]       cell_row,
    output logic [$clog2(MAX_LENGTH)-1:0]       cell_col,
    output logic [$clog2(MAX_LENGTH)-1:0]       rd_row,
    output logic [$clog2(MAX_LENGTH)-1:0]       rd_col
);

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int COL_W = $clog2((MAX_LENGTH < 4) ? 4 : MAX_LENGTH);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(MAX_LENGTH - 1);
    localparam logic [COL_W-1:0] MIN_COL_END = COL_W'(3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_FILL_DRAIN,
        ST_WALK_START,
        ST_WALK_NEXT,
        ST_WALK_LEFT,
        ST_WALK_DIAG,
        ST_WALK_CAP,
        ST_WALK_STEP,
        ST_WALK_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  a_last_reg, a_last_next;
    logic [IDX_W-1:0]  b_last_reg, b_last_next;
    logic [COL_W-1:0]  col_end_reg, col_end_next;
    logic              accept;

    // map a length register onto the last index used by a run
    function automatic logic [IDX_W-1:0] last_index(input logic [LEN_W-1:0] len);
        logic [IDX_W-1:0] res;
        if (len == '0)
        begin
            res = '0;
        end
        else if (int'(len) > MAX_LENGTH)
        begin
            res = LAST_IDX;
        end
        else
        begin
            res = IDX_W'(len - LEN_W'(1));
        end
        return res;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        a_last_next  = a_last_reg;
        b_last_next  = b_last_reg;
        col_end_next = col_end_reg;
        cmd          = '0;
        cell_row     = row_reg;
        cell_col     = col_reg[IDX_W-1:0];
        rd_row       = row_reg - IDX_W'(1);
        rd_col       = col_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (op == OP_LOAD_A)
                    begin
                        cmd.load_a = 1'b1;
                    end
                    else if (op == OP_LOAD_B)
                    begin
                        cmd.load_b = 1'b1;
                    end
                    else if (op == OP_RUN)
                    begin
                        cmd.start   = 1'b1;
                        a_last_next = last_index(curve_a_length);
                        b_last_next = last_index(curve_b_length);
                        // pad short rows so the row above is written before it is read
                        col_end_next = (COL_W'(a_last_next) < MIN_COL_END) ?
                                       MIN_COL_END : COL_W'(a_last_next);
                        row_next    = '0;
                        col_next    = '0;
                        state_next  = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FILL:
            begin
                cmd.issue = (col_reg <= COL_W'(a_last_reg));
                if (col_reg == col_end_reg)
                begin
                    col_next = '0;
                    if (row_reg == b_last_reg)
                    begin
                        state_next = ST_FILL_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            ST_FILL_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_WALK_START;
                end
            end

            ST_WALK_START:
            begin
                row_next   = b_last_reg;
                col_next   = COL_W'(a_last_reg);
                cell_row   = b_last_reg;
                cell_col   = a_last_reg;
                cmd.issue  = 1'b1;
                cmd.walk   = 1'b1;
                state_next = ST_WALK_NEXT;
            end

            ST_WALK_NEXT:
            begin
                priority if (row_reg == '0 && col_reg == '0)
                begin
                    state_next = ST_WALK_DRAIN;
                end
                else if (row_reg == '0)
                begin
                    col_next  = col_reg - COL_W'(1);
                    cell_col  = col_next[IDX_W-1:0];
                    cmd.issue = 1'b1;
                    cmd.walk  = 1'b1;
                end
                else if (col_reg == '0)
                begin
                    row_next  = row_reg - IDX_W'(1);
                    cell_row  = row_next;
                    cmd.issue = 1'b1;
                    cmd.walk  = 1'b1;
                end
                else
                begin
                    // read the up neighbour first
                    state_next = ST_WALK_LEFT;
                end
            end

            ST_WALK_LEFT:
            begin
                rd_row     = row_reg;
                rd_col     = col_reg[IDX_W-1:0] - IDX_W'(1);
                cmd.cap_up = 1'b1;
                state_next = ST_WALK_DIAG;
            end

            ST_WALK_DIAG:
            begin
                rd_col       = col_reg[IDX_W-1:0] - IDX_W'(1);
                cmd.cap_left = 1'b1;
                state_next   = ST_WALK_CAP;
            end

            ST_WALK_CAP:
            begin
                cmd.cap_diag = 1'b1;
                state_next   = ST_WALK_STEP;
            end

            ST_WALK_STEP:
            begin
                priority if (status.go_up)
                begin
                    row_next = row_reg - IDX_W'(1);
                end
                else if (status.go_left)
                begin
                    col_next = col_reg - COL_W'(1);
                end
                else
                begin
                    row_next = row_reg - IDX_W'(1);
                    col_next = col_reg - COL_W'(1);
                end
                cell_row   = row_next;
                cell_col   = col_next[IDX_W-1:0];
                cmd.issue  = 1'b1;
                cmd.walk   = 1'b1;
                state_next = ST_WALK_NEXT;
            end

            ST_WALK_DRAIN:
            begin
                // hold until the last path cell is summed and the output is free
                if (!status.busy && out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            a_last_reg  <= '0;
            b_last_reg  <= '0;
            col_end_reg <= MIN_COL_END;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            a_last_reg  <= a_last_next;
            b_last_reg  <= b_last_next;
            col_end_reg <= col_end_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dtwbt_dp.sv -----
// Datapath of the DTW core: sample and cost memories, distance pipeline, path sum.
`default_nettype none

module dtwbt_dp
    import dtwbt_pkg::*;
#(
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dtwbt_cmd_t                     cmd,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  cell_row,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  cell_col,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  rd_row,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  rd_col,
    input  wire logic [INDEX_W-1:0]             sample_index,
    input  wire logic signed [VALUE_W-1:0]      sample_value,
    output dtwbt_status_t                       status,
    output logic [COST_W-1:0]                   warp_cost,
    output logic [CELLS_W-1:0]                  path_cells,
    output logic                                cost_saturated
);

    localparam int IDX_W  = $clog2(MAX_LENGTH);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int EXT_W  = (SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int MAG_W  = SAMPLE_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SQX_W  = (SQ_W > COST_W) ? SQ_W : COST_W + 1;
    localparam logic signed [EXT_W-1:0] SAMPLE_MIN =
        {{(EXT_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic signed [EXT_W-1:0] SAMPLE_MAX =
        {{(EXT_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0] a_mem [MAX_LENGTH];
    logic signed [SAMPLE_BITS-1:0] b_mem [MAX_LENGTH];
    logic [COST_W-1:0]             cost_mem [2**ADDR_W];

    // load path
    logic signed [EXT_W-1:0]       value_ext;
    logic signed [EXT_W-1:0]       value_clamp;
    logic signed [SAMPLE_BITS-1:0] sample_store;
    logic                          index_ok;
    logic [IDX_W-1:0]              load_addr;

    // stage 1
    logic                          v1_reg, w1_reg;
    logic [IDX_W-1:0]              row1_reg, col1_reg;
    logic signed [SAMPLE_BITS-1:0] a_rd_reg, b_rd_reg;
    logic [COST_W-1:0]             cost_rd_reg;
    logic signed [DIFF_W-1:0]      diff1;
    logic [MAG_W-1:0]              mag1;

    // stage 2
    logic                          v2_reg, w2_reg;
    logic [IDX_W-1:0]              row2_reg, col2_reg;
    logic [MAG_W-1:0]              mag2_reg;
    logic [COST_W-1:0]             up2_reg, diag2_reg;
    logic [COST_W-1:0]             mdu2;
    logic [SQ_W-1:0]               sq2;

    // stage 3
    logic                          v3_reg, w3_reg;
    logic [IDX_W-1:0]              row3_reg, col3_reg;
    logic [SQ_W-1:0]               sq3_reg;
    logic [COST_W-1:0]             mdu3_reg;
    logic [SQX_W-1:0]              sq_ext;
    logic                          dist_sat;
    logic [COST_W-1:0]             cell_dist;
    logic [COST_W-1:0]             base;
    logic [COST_W:0]               sum_wide;
    logic                          add_sat;
    logic [COST_W-1:0]             total_next;
    logic                          cost_we;

    logic [COST_W-1:0]             left_reg;
    logic [COST_W-1:0]             sum_reg;
    logic [CELLS_W-1:0]            cells_reg;
    logic                          sat_reg;
    logic [COST_W-1:0]             up_cap_reg, left_cap_reg, diag_cap_reg;

    assign value_ext    = EXT_W'(sample_value);
    assign value_clamp  = (value_ext < SAMPLE_MIN) ? SAMPLE_MIN :
                          (value_ext > SAMPLE_MAX) ? SAMPLE_MAX : value_ext;
    assign sample_store = value_clamp[SAMPLE_BITS-1:0];
    assign index_ok     = (32'(sample_index) < 32'(MAX_LENGTH));
    assign load_addr    = IDX_W'(sample_index);

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && index_ok)
        begin
            a_mem[load_addr] <= sample_store;
        end
        a_rd_reg <= a_mem[cell_col];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b && index_ok)
        begin
            b_mem[load_addr] <= sample_store;
        end
        b_rd_reg <= b_mem[cell_row];
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[{row3_reg, col3_reg}] <= total_next;
        end
        cost_rd_reg <= cost_mem[{rd_row, rd_col}];
    end

    assign diff1 = DIFF_W'(a_rd_reg) - DIFF_W'(b_rd_reg);
    assign mag1  = diff1[DIFF_W-1] ? MAG_W'(-diff1) : MAG_W'(diff1);

    always_comb
    begin
        if (row2_reg == '0)
        begin
            mdu2 = COST_MAX;
        end
        else if (col2_reg == '0)
        begin
            mdu2 = up2_reg;
        end
        else
        begin
            mdu2 = (diag2_reg < up2_reg) ? diag2_reg : up2_reg;
        end
    end

    assign sq2 = mag2_reg * mag2_reg;

    assign sq_ext    = SQX_W'(sq3_reg);
    assign dist_sat  = |sq_ext[SQX_W-1:COST_W];
    assign cell_dist = dist_sat ? COST_MAX : sq_ext[COST_W-1:0];

    always_comb
    begin
        if (w3_reg)
        begin
            base = sum_reg;
        end
        else if (row3_reg == '0 && col3_reg == '0)
        begin
            base = '0;
        end
        else if (col3_reg == '0)
        begin
            base = mdu3_reg;
        end
        else
        begin
            base = (left_reg < mdu3_reg) ? left_reg : mdu3_reg;
        end
    end

    assign sum_wide   = {1'b0, base} + {1'b0, cell_dist};
    assign add_sat    = sum_wide[COST_W];
    assign total_next = add_sat ? COST_MAX : sum_wide[COST_W-1:0];
    assign cost_we    = v3_reg && !w3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            w1_reg <= 1'b0;
            v2_reg <= 1'b0;
            w2_reg <= 1'b0;
            v3_reg <= 1'b0;
            w3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            w1_reg <= cmd.walk;
            v2_reg <= v1_reg;
            w2_reg <= w1_reg;
            v3_reg <= v2_reg;
            w3_reg <= w2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row1_reg  <= cell_row;
        col1_reg  <= cell_col;
        row2_reg  <= row1_reg;
        col2_reg  <= col1_reg;
        mag2_reg  <= mag1;
        up2_reg   <= cost_rd_reg;
        // the previous cell's up neighbour is this cell's diagonal
        diag2_reg <= up2_reg;
        row3_reg  <= row2_reg;
        col3_reg  <= col2_reg;
        sq3_reg   <= sq2;
        mdu3_reg  <= mdu2;

        if (cmd.start)
        begin
            sum_reg   <= '0;
            cells_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (v3_reg)
        begin
            sat_reg <= sat_reg | dist_sat | add_sat;
            if (w3_reg)
            begin
                sum_reg   <= total_next;
                cells_reg <= (cells_reg == CELLS_MAX) ? cells_reg :
                             cells_reg + CELLS_W'(1);
            end
            else
            begin
                left_reg <= total_next;
            end
        end

        if (cmd.cap_up)
        begin
            up_cap_reg <= cost_rd_reg;
        end
        if (cmd.cap_left)
        begin
            left_cap_reg <= cost_rd_reg;
        end
        if (cmd.cap_diag)
        begin
            diag_cap_reg <= cost_rd_reg;
        end
    end

    // step preference: up, then left, then diagonal
    assign status.busy    = v1_reg || v2_reg || v3_reg;
    assign status.go_up   = (up_cap_reg <= diag_cap_reg) && (up_cap_reg <= left_cap_reg);
    assign status.go_left = (left_cap_reg <= diag_cap_reg);

    assign warp_cost      = sum_reg;
    assign path_cells     = cells_reg;
    assign cost_saturated = sat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dtw_distance_with_backtrack_core.sv -----
// Top level of the DTW distance core: stream ports, length registers, result register.
// Run transfer: a fill of B_len rows by max(A_len, 4) columns, one cell per cycle through a
// 3-stage distance pipeline, a drain, then a backtrack in which each inner step takes three
// reads of the single cost memory port, and a final drain.
// One run at a time; a waiting result holds the next run just before its own result.
// Reset (async, active low): lengths to 32, control idle; memories are not cleared.
`default_nettype none

module dtw_distance_with_backtrack_core
    import dtwbt_pkg::*;
#(
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // sample_index, sample_value
    input  wire logic [OP_W-1:0]        s_tuser,   // operation
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,   // path cost, path cells
    output logic                        m_tuser,   // cost_saturated
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]       cfg_data
);

    localparam int IDX_W = $clog2(MAX_LENGTH);

    logic [LEN_W-1:0]       curve_a_length_reg;
    logic [LEN_W-1:0]       curve_b_length_reg;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   out_free;

    dtwbt_cmd_t             cmd;
    dtwbt_status_t          status;
    logic [IDX_W-1:0]       cell_row, cell_col, rd_row, rd_col;
    logic [COST_W-1:0]      warp_cost;
    logic [CELLS_W-1:0]     path_cells;
    logic                   cost_saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_a_length_reg <= LEN_RESET;
            curve_b_length_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CURVE_A_LENGTH: curve_a_length_reg <= cfg_data;
                CFG_CURVE_B_LENGTH: curve_b_length_reg <= cfg_data;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    dtwbt_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .op             (s_tuser),
        .curve_a_length (curve_a_length_reg),
        .curve_b_length (curve_b_length_reg),
        .out_free       (out_free),
        .status         (status),
        .cmd            (cmd),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .rd_row         (rd_row),
        .rd_col         (rd_col)
    );

    dtwbt_dp #(
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .rd_row         (rd_row),
        .rd_col         (rd_col),
        .sample_index   (s_tdata[IN_INDEX_LSB +: INDEX_W]),
        .sample_value   (s_tdata[IN_VALUE_LSB +: VALUE_W]),
        .status         (status),
        .warp_cost      (warp_cost),
        .path_cells     (path_cells),
        .cost_saturated (cost_saturated)
    );

    // result register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.done)
        begin
            m_tdata_reg <= {{(OUT_DATA_W - CELLS_W - COST_W){1'b0}}, path_cells, warp_cost};
            m_tuser_reg <= cost_saturated;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a run blocks further input until its result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_RUN) |=> !s_tready)
        else $error("input accepted while a run is in progress");

    // a new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // every path holds at least its end cell
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_CELLS_LSB +: CELLS_W] != '0))
        else $error("result with empty path");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_a, cmd.load_b, cmd.start, cmd.done}))
        else $error("conflicting controller commands");

endmodule

`default_nettype wire
